// ===== rtl/ssc_pkg.sv =====
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types, character codes and classifier step functions for the
// statement splitter and classifier.
// ----------------------------------------------------------------------------
package ssc_pkg;

   localparam int unsigned MAX_TEXT_DEF = 65536;

   localparam int unsigned START_W = 16;
   localparam int unsigned LEN_W   = 17;
   localparam int unsigned LINE_W  = 17;
   localparam int unsigned KIND_W  = 3;
   localparam int unsigned DEPTH_W = 16;

   // character codes
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_M      = 8'h6D;
   localparam logic [7:0] CH_A      = 8'h61;
   localparam logic [7:0] CH_I      = 8'h69;
   localparam logic [7:0] CH_N      = 8'h6E;

   // statement kinds
   localparam logic [KIND_W-1:0] KIND_FUNCTION   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CONSTANT   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_VARIABLE   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ASSIGNMENT = 3'd3;
   localparam logic [KIND_W-1:0] KIND_EXPRESSION = 3'd4;

   // paren tracker codes
   localparam logic [1:0] TR_IDLE = 2'd0;
   localparam logic [1:0] TR_SCAN = 2'd1;
   localparam logic [1:0] TR_YES  = 2'd2;
   localparam logic [1:0] TR_NO   = 2'd3;

   // main matcher phases (0..3 are letters matched so far)
   localparam logic [2:0] MM_LAST = 3'd3;
   localparam logic [2:0] MM_SCAN = 3'd4;
   localparam logic [2:0] MM_YES  = 3'd5;
   localparam logic [2:0] MM_NO   = 3'd6;

   // colon flag bits
   localparam int unsigned CF_COLON      = 0;
   localparam int unsigned CF_COLONEQ    = 1;
   localparam int unsigned CF_EQ         = 2;
   localparam int unsigned CF_EQ_AFTER   = 3;
   localparam int unsigned CF_PREV_COLON = 4;

   typedef struct packed {
      logic       feed;
      logic       clear;
      logic [7:0] ch;
   } ssc_ctl_type;

   typedef struct packed {
      logic              nonblank;
      logic [KIND_W-1:0] kind;
      logic              main_def;
   } ssc_stat_type;

   typedef struct packed {
      logic               emit;
      logic               stmt_valid;
      logic [START_W-1:0] start;
      logic [LEN_W-1:0]   length;
      logic [LINE_W-1:0]  line;
      logic [KIND_W-1:0]  kind;
      logic               main_def;
      logic               done;
   } ssc_evt_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic is_ident(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h30 && c <= 8'h39) || (c == CH_UNDER);
   endfunction

   function automatic logic [1:0] tracker_step(input logic [1:0] t, input logic [7:0] c);
      logic [1:0] r;
      r = t;
      if (t == TR_SCAN && !is_ws(c)) begin
         r = (c == CH_LPAREN) ? TR_YES : TR_NO;
      end
      return r;
   endfunction

   // m = {prev_ident, candidate_blocked, phase[2:0]}
   function automatic logic [4:0] main_step(input logic [4:0] m, input logic [7:0] c);
      logic [2:0] phase;
      logic       cand;
      logic       prev;
      logic [7:0] want;
      phase = m[2:0];
      cand  = m[3];
      prev  = m[4];
      case (phase[1:0])
         2'd0:    want = CH_M;
         2'd1:    want = CH_A;
         2'd2:    want = CH_I;
         default: want = CH_N;
      endcase
      if (phase < MM_SCAN) begin
         if (c == want) begin
            if (phase == 3'd0) cand = prev;
            if (phase == MM_LAST) phase = cand ? MM_NO : MM_SCAN;
            else phase = phase + 3'd1;
         end else if (c == CH_M) begin
            phase = 3'd1;
            cand  = prev;
         end else begin
            phase = 3'd0;
         end
      end else if (phase == MM_SCAN) begin
         if (!is_ws(c)) phase = (c == CH_COLON) ? MM_YES : MM_NO;
      end
      prev = is_ident(c);
      return {prev, cand, phase};
   endfunction

endpackage

// ===== rtl/ssc_class.sv =====
// ----------------------------------------------------------------------------
// ssc_class
// Per-statement classifier: colon/equals flags, paren trackers and the
// main-definition matcher. Reports blank status, kind and main flag.
// ----------------------------------------------------------------------------
module ssc_class (
   input  logic                 clock,
   input  logic                 reset,
   input  ssc_pkg::ssc_ctl_type ctl,
   output ssc_pkg::ssc_stat_type stat
);
   import ssc_pkg::*;

   logic       nonblank_ff, nonblank_in;
   logic [4:0] flags_ff, flags_in;
   logic [1:0] trk_a_ff, trk_a_in;
   logic [1:0] trk_b_ff, trk_b_in;
   logic [4:0] mm_ff, mm_in;
   logic [1:0] trk_sel;
   logic [KIND_W-1:0] kind_now;

   always_comb begin
      nonblank_in = nonblank_ff;
      flags_in    = flags_ff;
      trk_a_in    = trk_a_ff;
      trk_b_in    = trk_b_ff;
      mm_in       = mm_ff;
      if (ctl.clear) begin
         nonblank_in = 1'b0;
         flags_in    = '0;
         trk_a_in    = TR_IDLE;
         trk_b_in    = TR_IDLE;
         mm_in       = '0;
      end else if (ctl.feed) begin
         if (!is_ws(ctl.ch)) nonblank_in = 1'b1;
         trk_a_in = tracker_step(trk_a_ff, ctl.ch);
         trk_b_in = tracker_step(trk_b_ff, ctl.ch);
         if (ctl.ch == CH_EQ) begin
            if (flags_ff[CF_PREV_COLON] && !flags_ff[CF_COLONEQ]) begin
               flags_in[CF_COLONEQ] = 1'b1;
               trk_a_in = TR_SCAN;
            end
            if (!flags_ff[CF_EQ]) begin
               flags_in[CF_EQ] = 1'b1;
               if (flags_ff[CF_COLON]) flags_in[CF_EQ_AFTER] = 1'b1;
            end
         end
         if (ctl.ch == CH_COLON && !flags_ff[CF_COLON]) begin
            flags_in[CF_COLON] = 1'b1;
            trk_b_in = TR_SCAN;
         end
         flags_in[CF_PREV_COLON] = (ctl.ch == CH_COLON);
         mm_in = main_step(mm_ff, ctl.ch);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nonblank_ff <= 1'b0;
         flags_ff    <= '0;
         trk_a_ff    <= TR_IDLE;
         trk_b_ff    <= TR_IDLE;
         mm_ff       <= '0;
      end else begin
         nonblank_ff <= nonblank_in;
         flags_ff    <= flags_in;
         trk_a_ff    <= trk_a_in;
         trk_b_ff    <= trk_b_in;
         mm_ff       <= mm_in;
      end
   end

   // ":=" tracker wins when a ":=" was seen, else the first-colon tracker
   assign trk_sel = flags_ff[CF_COLONEQ] ? trk_a_ff : trk_b_ff;

   always_comb begin
      if (flags_ff[CF_COLON]) begin
         if (trk_sel == TR_YES) kind_now = KIND_FUNCTION;
         else if (flags_ff[CF_EQ] && flags_ff[CF_EQ_AFTER]) kind_now = KIND_CONSTANT;
         else kind_now = KIND_VARIABLE;
      end else begin
         kind_now = flags_ff[CF_EQ] ? KIND_ASSIGNMENT : KIND_EXPRESSION;
      end
   end

   assign stat.kind     = kind_now;
   assign stat.nonblank = nonblank_ff;
   assign stat.main_def = (mm_ff[2:0] == MM_YES);

endmodule

// ===== rtl/ssc_scan.sv =====
// ----------------------------------------------------------------------------
// ssc_scan
// Text scanner: position, line count, escape, quote and bracket depth.
// Finds statement boundaries, drives the classifier and forms results.
// ----------------------------------------------------------------------------
module ssc_scan #(
   parameter int unsigned MAX_TEXT = ssc_pkg::MAX_TEXT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  go,
   input  logic [7:0]            ch,
   input  logic                  eot,
   input  ssc_pkg::ssc_stat_type stat,
   output ssc_pkg::ssc_ctl_type  ctl,
   output ssc_pkg::ssc_evt_type  evt
);
   import ssc_pkg::*;

   localparam int unsigned PW = $clog2(MAX_TEXT + 1);
   localparam int unsigned DW = (PW > LEN_W) ? PW : LEN_W;

   logic [PW-1:0]      pos_ff, pos_in;
   logic [PW-1:0]      start_ff, start_in;
   logic [LINE_W-1:0]  line_ff, line_in;
   logic               esc_ff, esc_in;
   logic               quote_ff, quote_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;

   logic               active;
   logic               is_nl;
   logic               sep;
   logic [LINE_W-1:0]  line_now;
   logic [DW-1:0]      pos_x, start_x, len_x;

   assign active   = go && !eot && (pos_ff < PW'(MAX_TEXT));
   assign is_nl    = (ch == CH_NL);
   assign sep      = !quote_ff && (depth_ff == '0) && (ch == CH_SEMI || is_nl);
   assign line_now = line_ff + LINE_W'(is_nl);

   always_comb begin
      pos_in   = pos_ff;
      start_in = start_ff;
      line_in  = line_ff;
      esc_in   = esc_ff;
      quote_in = quote_ff;
      depth_in = depth_ff;
      if (go && eot) begin
         pos_in   = '0;
         start_in = '0;
         line_in  = LINE_W'(1);
         esc_in   = 1'b0;
         quote_in = 1'b0;
         depth_in = '0;
      end else if (active) begin
         line_in = line_now;
         pos_in  = pos_ff + PW'(1);
         if (sep) start_in = pos_ff + PW'(1);
         if (esc_ff) begin
            esc_in = 1'b0;
         end else if (ch == CH_BSLASH) begin
            esc_in = 1'b1;
         end else if (ch == CH_DQUOTE || ch == CH_SQUOTE) begin
            quote_in = !quote_ff;
         end else if (!quote_ff) begin
            if (ch == CH_LPAREN || ch == CH_LBRACK || ch == CH_LBRACE) begin
               if (depth_ff != '1) depth_in = depth_ff + DEPTH_W'(1);
            end else if (ch == CH_RPAREN || ch == CH_RBRACK || ch == CH_RBRACE) begin
               if (depth_ff != '0) depth_in = depth_ff - DEPTH_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         start_ff <= '0;
         line_ff  <= LINE_W'(1);
         esc_ff   <= 1'b0;
         quote_ff <= 1'b0;
         depth_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         start_ff <= start_in;
         line_ff  <= line_in;
         esc_ff   <= esc_in;
         quote_ff <= quote_in;
         depth_ff <= depth_in;
      end
   end

   assign ctl.ch    = ch;
   assign ctl.clear = (go && eot) || (active && sep);
   assign ctl.feed  = active && !sep;

   assign pos_x   = DW'(pos_ff);
   assign start_x = DW'(start_ff);
   assign len_x   = pos_x - start_x;

   always_comb begin
      evt.emit       = (go && eot) || (active && sep && stat.nonblank);
      evt.stmt_valid = stat.nonblank;
      evt.done       = eot;
      evt.start      = '0;
      evt.length     = '0;
      evt.line       = '0;
      evt.kind       = '0;
      evt.main_def   = 1'b0;
      if (stat.nonblank) begin
         evt.start    = start_x[START_W-1:0];
         evt.length   = len_x[LEN_W-1:0];
         evt.line     = eot ? line_ff : line_now;
         evt.kind     = stat.kind;
         evt.main_def = stat.main_def;
      end
   end

endmodule

// ===== rtl/statement_splitter_classifier.sv =====
// ----------------------------------------------------------------------------
// statement_splitter_classifier
// Splits a byte stream into statements and classifies each one.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel req_*: one text byte per word, or an end marker
//   (req_end_of_text = 1). Result channel rsp_*: one word per reported
//   statement, plus one word with rsp_text_done = 1 for each end marker.
//   Both channels move a word on a clock edge with valid high and stall low.
//   A byte accepted into the input register is scanned once the result register
//   is free, and its result, if any, is registered in the result register.
//   Throughput: one byte per cycle while the result register is free; the
//   scanner state (position, quote, bracket depth, classifier flags) updates
//   once per byte. Every byte, even one that yields no result, waits while a
//   result is held. When rsp_stall holds a pending result, the input register
//   stalls once it is full, so req_stall rises after one more word.
//   Reset (synchronous, active high) clears the scanner to position 0,
//   line 1, and empties both registers. The end marker does the same to the
//   scanner as its result is registered.
// ----------------------------------------------------------------------------
module statement_splitter_classifier #(
   parameter int unsigned MAX_TEXT = ssc_pkg::MAX_TEXT_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [7:0]                   req_ch,
   input  logic                         req_end_of_text,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_stmt_valid,
   output logic [ssc_pkg::START_W-1:0]  rsp_stmt_start,
   output logic [ssc_pkg::LEN_W-1:0]    rsp_stmt_length,
   output logic [ssc_pkg::LINE_W-1:0]   rsp_line_number,
   output logic [ssc_pkg::KIND_W-1:0]   rsp_stmt_kind,
   output logic                         rsp_defines_main,
   output logic                         rsp_text_done
);
   import ssc_pkg::*;

   logic         in_valid_ff, in_valid_in;
   logic [7:0]   in_ch_ff;
   logic         in_eot_ff;
   logic         out_valid_ff, out_valid_in;
   ssc_evt_type  out_ff;
   logic         out_free;
   logic         go;
   ssc_ctl_type  ctl;
   ssc_stat_type stat;
   ssc_evt_type  evt;

   // advance when the result register is empty or being drained
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign go        = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign out_valid_in = out_free ? (go && evt.emit) : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ch_ff  <= req_ch;
         in_eot_ff <= req_end_of_text;
      end
      if (go && evt.emit) out_ff <= evt;
   end

   ssc_scan #(
      .MAX_TEXT (MAX_TEXT)
   ) u_scan (
      .clock (clock),
      .reset (reset),
      .go    (go),
      .ch    (in_ch_ff),
      .eot   (in_eot_ff),
      .stat  (stat),
      .ctl   (ctl),
      .evt   (evt)
   );

   ssc_class u_class (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .stat  (stat)
   );

   assign rsp_valid        = out_valid_ff;
   assign rsp_stmt_valid   = out_ff.stmt_valid;
   assign rsp_stmt_start   = out_ff.start;
   assign rsp_stmt_length  = out_ff.length;
   assign rsp_line_number  = out_ff.line;
   assign rsp_stmt_kind    = out_ff.kind;
   assign rsp_defines_main = out_ff.main_def;
   assign rsp_text_done    = out_ff.done;

endmodule

// ===== sim/ssc_checker.sv =====
// ----------------------------------------------------------------------------
// ssc_checker
// Watches both channels of the statement splitter, predicts the result word
// for each nonblank statement a byte closes and each end marker, and compares
// each accepted result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module ssc_checker #(
   parameter int unsigned MAX_TEXT = ssc_pkg::MAX_TEXT_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [7:0]                   req_ch,
   input  logic                         req_end_of_text,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic                         rsp_stmt_valid,
   input  logic [ssc_pkg::START_W-1:0]  rsp_stmt_start,
   input  logic [ssc_pkg::LEN_W-1:0]    rsp_stmt_length,
   input  logic [ssc_pkg::LINE_W-1:0]   rsp_line_number,
   input  logic [ssc_pkg::KIND_W-1:0]   rsp_stmt_kind,
   input  logic                         rsp_defines_main,
   input  logic                         rsp_text_done,
   output int                           fail_count,
   output int                           words_pending
);
   import ssc_pkg::*;

   typedef struct packed {
      logic               found;
      logic [START_W-1:0] start;
      logic [LEN_W-1:0]   length;
      logic [LINE_W-1:0]  line;
      logic [KIND_W-1:0]  kind;
      logic               main_def;
      logic               done;
   } stmt_report_type;

   stmt_report_type predicted_stmts[$];
   int           words_seen;

   // scanner copy
   int unsigned  text_pos;
   int unsigned  stmt_begin;
   int unsigned  line_no;
   logic         escaped;
   logic         quoted;
   int unsigned  depth;
   logic         nonblank;

   // classifier copy
   logic         seen_colon;
   logic         seen_coloneq;
   logic         seen_eq;
   logic         eq_after_colon;
   logic         last_was_colon;
   logic [1:0]   paren_after_assign;
   logic [1:0]   paren_after_colon;
   logic [2:0]   mm_phase;
   logic         mm_blocked;
   logic         mm_prev_word;

   function automatic logic is_blank(input logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic is_word_char(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
             (c >= "0" && c <= "9") || c == CH_UNDER;
   endfunction

   function automatic logic [7:0] main_letter(input logic [1:0] idx);
      case (idx)
         2'd0: return CH_M;
         2'd1: return CH_A;
         2'd2: return CH_I;
         default: return CH_N;
      endcase
   endfunction

   function automatic logic [1:0] paren_watch(input logic [1:0] t, input logic [7:0] c);
      if (t != TR_SCAN || is_blank(c)) return t;
      return (c == CH_LPAREN) ? TR_YES : TR_NO;
   endfunction

   function automatic logic [KIND_W-1:0] stmt_kind_now();
      logic [1:0] t;
      if (seen_colon) begin
         t = seen_coloneq ? paren_after_assign : paren_after_colon;
         if (t == TR_YES) return KIND_FUNCTION;
         if (seen_eq && eq_after_colon) return KIND_CONSTANT;
         return KIND_VARIABLE;
      end
      return seen_eq ? KIND_ASSIGNMENT : KIND_EXPRESSION;
   endfunction

   task automatic clear_stmt();
      nonblank           = 1'b0;
      seen_colon         = 1'b0;
      seen_coloneq       = 1'b0;
      seen_eq            = 1'b0;
      eq_after_colon     = 1'b0;
      last_was_colon     = 1'b0;
      paren_after_assign = TR_IDLE;
      paren_after_colon  = TR_IDLE;
      mm_phase           = 3'd0;
      mm_blocked         = 1'b0;
      mm_prev_word       = 1'b0;
   endtask

   task automatic restart_text();
      text_pos   = 0;
      stmt_begin = 0;
      line_no    = 1;
      escaped    = 1'b0;
      quoted     = 1'b0;
      depth      = 0;
      clear_stmt();
   endtask

   task automatic push_report(input logic done);
      stmt_report_type r;
      r = '0;
      if (nonblank) begin
         r.found    = 1'b1;
         r.start    = stmt_begin[START_W-1:0];
         r.length   = LEN_W'(text_pos - stmt_begin);
         r.line     = line_no[LINE_W-1:0];
         r.kind     = stmt_kind_now();
         r.main_def = (mm_phase == MM_YES);
      end
      r.done = done;
      predicted_stmts.push_back(r);
   endtask

   task automatic track_main(input logic [7:0] c);
      if (mm_phase < MM_SCAN) begin
         if (c == main_letter(mm_phase[1:0])) begin
            if (mm_phase == 3'd0) mm_blocked = mm_prev_word;
            if (mm_phase == MM_LAST) mm_phase = mm_blocked ? MM_NO : MM_SCAN;
            else mm_phase = mm_phase + 3'd1;
         end else if (c == CH_M) begin
            mm_phase   = 3'd1;
            mm_blocked = mm_prev_word;
         end else begin
            mm_phase = 3'd0;
         end
      end else if (mm_phase == MM_SCAN && !is_blank(c)) begin
         mm_phase = (c == CH_COLON) ? MM_YES : MM_NO;
      end
      mm_prev_word = is_word_char(c);
   endtask

   task automatic classify_byte(input logic [7:0] c);
      if (!is_blank(c)) nonblank = 1'b1;
      paren_after_assign = paren_watch(paren_after_assign, c);
      paren_after_colon  = paren_watch(paren_after_colon, c);
      if (c == CH_EQ) begin
         if (last_was_colon && !seen_coloneq) begin
            seen_coloneq       = 1'b1;
            paren_after_assign = TR_SCAN;
         end
         if (!seen_eq) begin
            seen_eq        = 1'b1;
            eq_after_colon = seen_colon;
         end
      end
      if (c == CH_COLON && !seen_colon) begin
         seen_colon        = 1'b1;
         paren_after_colon = TR_SCAN;
      end
      last_was_colon = (c == CH_COLON);
      track_main(c);
   endtask

   task automatic scan_text_byte(input logic [7:0] c, input logic eot);
      logic closes;
      if (eot) begin
         push_report(1'b1);
         restart_text();
         return;
      end
      // drop bytes past the text limit
      if (text_pos >= MAX_TEXT) return;
      if (c == CH_NL) line_no++;
      closes = !quoted && depth == 0 && (c == CH_SEMI || c == CH_NL);
      if (escaped) begin
         escaped = 1'b0;
      end else if (c == CH_BSLASH) begin
         escaped = 1'b1;
      end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
         quoted = !quoted;
      end else if (!quoted) begin
         if (c == CH_LPAREN || c == CH_LBRACK || c == CH_LBRACE) begin
            if (depth < 65535) depth++;
         end else if (c == CH_RPAREN || c == CH_RBRACK || c == CH_RBRACE) begin
            if (depth > 0) depth--;
         end
      end
      if (closes) begin
         if (nonblank) push_report(1'b0);
         clear_stmt();
         stmt_begin = text_pos + 1;
      end else begin
         classify_byte(c);
      end
      text_pos++;
   endtask

   task automatic report(input string msg);
      $display("[%0t] ssc_checker: word %0d: %s", $time, words_seen, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [16:0] got,
                              input logic [16:0] want);
      if (got !== want) report($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   task automatic compare_word();
      stmt_report_type want;
      if (predicted_stmts.size() == 0) begin
         report("result word arrived with nothing expected");
      end else begin
         want = predicted_stmts.pop_front();
         check_field("stmt_valid", 17'(rsp_stmt_valid), 17'(want.found));
         check_field("stmt_start", 17'(rsp_stmt_start), 17'(want.start));
         check_field("stmt_length", rsp_stmt_length, want.length);
         check_field("line_number", rsp_line_number, want.line);
         check_field("stmt_kind", 17'(rsp_stmt_kind), 17'(want.kind));
         check_field("defines_main", 17'(rsp_defines_main), 17'(want.main_def));
         check_field("text_done", 17'(rsp_text_done), 17'(want.done));
      end
      words_seen++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restart_text();
         predicted_stmts.delete();
         words_seen = 0;
      end else begin
         if (rsp_valid && !rsp_stall) compare_word();
         if (req_valid && !req_stall) scan_text_byte(req_ch, req_end_of_text);
      end
      words_pending = predicted_stmts.size();
   end

endmodule

// ===== sim/tb_statement_splitter_classifier.sv =====
// ----------------------------------------------------------------------------
// tb_statement_splitter_classifier
// Feeds source text to the statement splitter: a directed set of statements
// covering every kind and corner, random statement streams with noise and a
// back-pressure phase. The checker beside the block predicts and compares
// every result word.
// ----------------------------------------------------------------------------
module tb_statement_splitter_classifier;
   import ssc_pkg::*;

   localparam int unsigned MAX_TEXT   = MAX_TEXT_DEF;
   localparam int          LONG_HOLD  = 400;
   localparam int          IDLE_LIMIT = 5000;
   localparam int          DRAIN_WAIT = 20;
   localparam int          RANDOM_BYTES = 500;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [7:0]         req_ch;
   logic               req_end_of_text;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_stmt_valid;
   logic [START_W-1:0] rsp_stmt_start;
   logic [LEN_W-1:0]   rsp_stmt_length;
   logic [LINE_W-1:0]  rsp_line_number;
   logic [KIND_W-1:0]  rsp_stmt_kind;
   logic               rsp_defines_main;
   logic               rsp_text_done;

   int                 fail_count;
   int                 words_pending;
   int                 idle_cycles;
   int                 hold_requests;
   int                 holds_served;
   int                 burst_left;
   logic               gaps_on;
   logic [7:0]         text_q[$];

   always #5 clock = ~clock;

   statement_splitter_classifier #(.MAX_TEXT(MAX_TEXT)) dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_ch, .req_end_of_text,
      .rsp_valid, .rsp_stall, .rsp_stmt_valid, .rsp_stmt_start, .rsp_stmt_length,
      .rsp_line_number, .rsp_stmt_kind, .rsp_defines_main, .rsp_text_done
   );

   ssc_checker #(.MAX_TEXT(MAX_TEXT)) u_checker (
      .clock, .reset,
      .req_valid, .req_stall, .req_ch, .req_end_of_text,
      .rsp_valid, .rsp_stall, .rsp_stmt_valid, .rsp_stmt_start, .rsp_stmt_length,
      .rsp_line_number, .rsp_stmt_kind, .rsp_defines_main, .rsp_text_done,
      .fail_count, .words_pending
   );

   // end the run when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("** statement_splitter_classifier: FAILED **");
            $finish;
         end
      end
   end

   // result side: random stall spans, plus a long hold on request
   initial begin
      int pct;
      int span;
      pct = 0;
      span = 0;
      holds_served = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served != hold_requests) begin
            rsp_stall = 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            rsp_stall = 1'b0;
            holds_served = hold_requests;
         end else begin
            if (span == 0) begin
               span = $urandom_range(16, 96);
               pct  = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 85);
            end
            span--;
            rsp_stall = ($urandom_range(99) < pct);
         end
      end
   end

   task automatic push_byte(input logic [7:0] c);
      text_q.push_back(c);
   endtask

   task automatic push_str(input string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   // present one word and hold it until accepted
   task automatic put_word(input logic [7:0] c, input logic eot);
      if (gaps_on && burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = $urandom_range(1, 30);
      end
      req_valid       = 1'b1;
      req_ch          = c;
      req_end_of_text = eot;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (burst_left > 0) burst_left--;
      @(negedge clock);
   endtask

   task automatic send_text();
      foreach (text_q[i]) put_word(text_q[i], 1'b0);
      put_word(8'($urandom_range(255)), 1'b1);
      text_q.delete();
   endtask

   task automatic drain_results();
      req_valid = 1'b0;
      while (words_pending != 0) @(negedge clock);
   endtask

   task automatic add_fragment();
      case ($urandom_range(0, 27))
         0:  push_str("main");
         1:  push_str("xmain");
         2:  push_str("_main");
         3:  push_str("ma");
         4:  push_str(":");
         5:  push_str(":=");
         6:  push_str("=");
         7:  push_str("(");
         8:  push_str(")");
         9:  push_str("[");
         10: push_str("]");
         11: push_str("{");
         12: push_str("}");
         13: push_str("\"");
         14: push_str("'");
         15: push_str("\\");
         16: push_byte(($urandom_range(4) == 0) ? CH_SPACE : 8'($urandom_range(9, 13)));
         17: push_byte(8'($urandom_range(8'h61, 8'h7A)));
         18: push_byte(8'($urandom_range(8'h30, 8'h39)));
         19: push_str(";");
         20: push_byte(CH_NL);
         21: push_byte(8'($urandom_range(255)));
         22: push_str("9main");
         23: push_str(" ");
         24: push_str("f := (");
         25: push_str("g: (");
         26: push_str("k: v = 1");
         default: push_str("main :");
      endcase
   endtask

   // mostly well-formed statements; now and then raw noise
   task automatic build_random_text();
      int n;
      if ($urandom_range(6) == 0) begin
         n = $urandom_range(1, 30);
         for (int j = 0; j < n; j++) push_byte(8'($urandom_range(255)));
      end else begin
         n = $urandom_range(1, 6);
         for (int k = 0; k < n; k++) begin
            for (int j = $urandom_range(1, 8); j > 0; j--) add_fragment();
            if (k < n - 1 || $urandom_range(1) == 1)
               push_byte(($urandom_range(1) == 1) ? CH_SEMI : CH_NL);
         end
      end
   endtask

   initial begin
      int sent;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_ch          = 8'h00;
      req_end_of_text = 1'b0;
      gaps_on         = 1'b0;
      burst_left      = 0;
      hold_requests   = 0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // every kind, main detection, escaped separator, stray closer, blanks
      push_str("f:=(x);c: b=1\n)main :x;\\;v:=2 \n\"a;\"=0;xmain:(y);;");
      push_byte(8'h00);
      push_byte(8'hFF);
      push_str(" g: (");
      send_text();
      // blank tail: end marker with no statement
      for (int c = 9; c <= 13; c++) push_byte(8'(c));
      push_str(" ");
      send_text();
      // end marker inside quotes and brackets
      push_str("q=[\"open;");
      send_text();
      drain_results();

      // hold the result side while offering many short statements
      hold_requests++;
      for (int i = 0; i < 40; i++) push_str("a;");
      send_text();
      drain_results();

      sent = 0;
      while (sent < RANDOM_BYTES) begin
         gaps_on = ($urandom_range(3) != 0);
         build_random_text();
         sent += text_q.size() + 1;
         send_text();
         if ($urandom_range(7) == 0) drain_results();
      end

      drain_results();
      repeat (DRAIN_WAIT) @(negedge clock);
      if (fail_count == 0 && words_pending == 0) begin
         $display("** statement_splitter_classifier: PASSED **");
      end else begin
         $display("** statement_splitter_classifier: FAILED **");
      end
      $finish;
   end

endmodule
